/* rtl/klein_nishina_angular_weight_defines.svh */
// Assertion macros shared by the RTL.
`ifndef KLEIN_NISHINA_ANGULAR_WEIGHT_DEFINES_SVH
`define KLEIN_NISHINA_ANGULAR_WEIGHT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define KNAW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Checked on every edge, reset included.
`define KNAW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define KNAW_ASSERT(lbl, prop)
`define KNAW_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/knaw_pkg.sv */
package knaw_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int ENERGY_BITS_DEF = 14;

  // electron rest energy in keV
  localparam int REST_KEV = 511;

  // 2^MOD_SHIFT = REST_KEV + 1, used for the mod-511 folding
  localparam int MOD_SHIFT = 9;

endpackage

/* rtl/knaw_front.sv */
module knaw_front #(
  parameter int FRAC_BITS   = knaw_pkg::FRAC_BITS_DEF,
  parameter int ENERGY_BITS = knaw_pkg::ENERGY_BITS_DEF
) (
  input  logic                          clk,
  input  logic [2:0]                    en,
  input  logic signed [FRAC_BITS+1:0]   cos_angle,
  input  logic [ENERGY_BITS-1:0]        energy_kev,
  output logic [2*FRAC_BITS:0]          s_rem,
  output logic [FRAC_BITS:0]            s_root,
  output logic [FRAC_BITS:0]            s2,
  output logic [((FRAC_BITS+9 > ENERGY_BITS+FRAC_BITS+1) ?
                 FRAC_BITS+9 : ENERGY_BITS+FRAC_BITS+1):0] dv,
  output logic [((FRAC_BITS+9 > ENERGY_BITS+FRAC_BITS+1) ?
                 FRAC_BITS+9 : ENERGY_BITS+FRAC_BITS+1):0] d_r,
  output logic [FRAC_BITS:0]            d_q,
  output logic [ENERGY_BITS+FRAC_BITS:0] m_r,
  output logic [ENERGY_BITS+FRAC_BITS-8:0] m_q
);

  localparam int F     = FRAC_BITS;
  localparam int E     = ENERGY_BITS;
  localparam int CW    = F + 2;
  localparam int SQ_W  = 2*F + 1;
  localparam int EO_W  = E + F + 1;
  localparam int AV_W  = F + 9;
  localparam int D_W   = ((AV_W > EO_W) ? AV_W : EO_W) + 1;

  localparam logic signed [CW-1:0] ONE_S     = {2'b01, {F{1'b0}}};
  localparam logic signed [CW-1:0] NEG_ONE_S = {2'b11, {F{1'b0}}};
  localparam logic [SQ_W-1:0]      ONE_SQ    = {1'b1, {(2*F){1'b0}}};
  localparam logic [D_W-1:0]       AV        = D_W'(knaw_pkg::REST_KEV) << F;

  // stage 1: clip, 1 - c, |c|
  logic signed [CW-1:0] c_clip;
  logic [CW-1:0]        omc_c;
  logic signed [CW-1:0] ac_c;
  logic [CW-1:0]        omc1;
  logic [F:0]           ac1;
  logic [E-1:0]         e1;

  always_comb begin
    if (cos_angle > ONE_S) begin
      c_clip = ONE_S;
    end else if (cos_angle < NEG_ONE_S) begin
      c_clip = NEG_ONE_S;
    end else begin
      c_clip = cos_angle;
    end
    omc_c = ONE_S - c_clip;
    ac_c  = c_clip[CW-1] ? -c_clip : c_clip;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      omc1 <= omc_c;
      ac1  <= ac_c[F:0];
      e1   <= energy_kev;
    end
  end

  // stage 2: c^2 and E*(1-c)
  logic [2*F+1:0]   ac_prod;
  logic [E+F+1:0]   eo_prod;
  logic [SQ_W-1:0]  ac2;
  logic [EO_W-1:0]  eo2;

  assign ac_prod = ac1 * ac1;
  assign eo_prod = e1 * omc1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ac2 <= ac_prod[SQ_W-1:0];
      eo2 <= eo_prod[EO_W-1:0];
    end
  end

  // stage 3: sin^2, divisor, seeds of the three iterations
  logic [SQ_W-1:0] s2w;
  logic            eo_zero;

  assign s2w     = ONE_SQ - ac2;
  assign eo_zero = (eo2 == '0);
  assign s_root  = '0;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s_rem <= s2w;
      s2    <= s2w[SQ_W-1:F];
      dv    <= AV + D_W'(eo2);
      d_q   <= {{F{1'b0}}, eo_zero};
      d_r   <= eo_zero ? '0 : AV;
      m_r   <= eo2;
      m_q   <= '0;
    end
  end

endmodule

/* rtl/knaw_iter.sv */
module knaw_iter #(
  parameter int FRAC_BITS   = knaw_pkg::FRAC_BITS_DEF,
  parameter int ENERGY_BITS = knaw_pkg::ENERGY_BITS_DEF,
  parameter int STEP        = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*FRAC_BITS:0] pre_rem,
  input  logic [FRAC_BITS:0]   pre_root,
  input  logic [FRAC_BITS:0]   pre_s2,
  input  logic [((FRAC_BITS+9 > ENERGY_BITS+FRAC_BITS+1) ?
                 FRAC_BITS+9 : ENERGY_BITS+FRAC_BITS+1):0] pre_dv,
  input  logic [((FRAC_BITS+9 > ENERGY_BITS+FRAC_BITS+1) ?
                 FRAC_BITS+9 : ENERGY_BITS+FRAC_BITS+1):0] pre_d_r,
  input  logic [FRAC_BITS:0]   pre_d_q,
  input  logic [ENERGY_BITS+FRAC_BITS:0]   pre_m_r,
  input  logic [ENERGY_BITS+FRAC_BITS-8:0] pre_m_q,
  output logic [2*FRAC_BITS:0] rem,
  output logic [FRAC_BITS:0]   root,
  output logic [FRAC_BITS:0]   s2,
  output logic [((FRAC_BITS+9 > ENERGY_BITS+FRAC_BITS+1) ?
                 FRAC_BITS+9 : ENERGY_BITS+FRAC_BITS+1):0] dv,
  output logic [((FRAC_BITS+9 > ENERGY_BITS+FRAC_BITS+1) ?
                 FRAC_BITS+9 : ENERGY_BITS+FRAC_BITS+1):0] d_r,
  output logic [FRAC_BITS:0]   d_q,
  output logic [ENERGY_BITS+FRAC_BITS:0]   m_r,
  output logic [ENERGY_BITS+FRAC_BITS-8:0] m_q
);

  localparam int F     = FRAC_BITS;
  localparam int E     = ENERGY_BITS;
  localparam int SQ_W  = 2*F + 1;
  localparam int ST_W  = 2*F + 3;
  localparam int EO_W  = E + F + 1;
  localparam int AV_W  = F + 9;
  localparam int D_W   = ((AV_W > EO_W) ? AV_W : EO_W) + 1;
  localparam int Q5_W  = EO_W - 8;
  localparam int BIT_I = F - STEP;
  localparam int MS    = knaw_pkg::MOD_SHIFT;

  // square root: one result bit
  logic [ST_W-1:0] trial;
  logic [ST_W-1:0] rem_ext;
  logic            take;
  logic [SQ_W-1:0] rem_next;
  logic [F:0]      root_next;

  assign trial   = (ST_W'(pre_root) << (BIT_I + 1)) + (ST_W'(1) << (2*BIT_I));
  assign rem_ext = ST_W'(pre_rem);
  assign take    = (rem_ext >= trial);

  always_comb begin
    rem_next  = pre_rem;
    root_next = pre_root;
    if (take) begin
      rem_next  = pre_rem - trial[SQ_W-1:0];
      root_next = pre_root | ((F+1)'(1) << BIT_I);
    end
  end

  // divide: one quotient bit (only F steps needed)
  logic [D_W-1:0] d_r_next;
  logic [F:0]     d_q_next;

  generate
    if (STEP < F) begin : g_div
      logic [D_W:0] r2;
      logic [D_W:0] r2_sub;
      assign r2     = {pre_d_r, 1'b0};
      assign r2_sub = r2 - pre_dv;
      always_comb begin
        if (r2 >= pre_dv) begin
          d_r_next = r2_sub[D_W-1:0];
          d_q_next = {pre_d_q[F-1:0], 1'b1};
        end else begin
          d_r_next = r2[D_W-1:0];
          d_q_next = {pre_d_q[F-1:0], 1'b0};
        end
      end
    end else begin : g_hold
      assign d_r_next = pre_d_r;
      assign d_q_next = pre_d_q;
    end
  endgenerate

  // divide by 511: x = 512*hi + lo = 511*hi + (hi + lo)
  logic [EO_W-1:0] hi;
  logic [EO_W-1:0] lo;

  assign hi = pre_m_r >> MS;
  assign lo = EO_W'(pre_m_r[MS-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      root <= root_next;
      s2   <= pre_s2;
      dv   <= pre_dv;
      d_r  <= d_r_next;
      d_q  <= d_q_next;
      m_r  <= hi + lo;
      m_q  <= pre_m_q + hi[Q5_W-1:0];
    end
  end

endmodule

/* rtl/knaw_back.sv */
module knaw_back #(
  parameter int FRAC_BITS   = knaw_pkg::FRAC_BITS_DEF,
  parameter int ENERGY_BITS = knaw_pkg::ENERGY_BITS_DEF
) (
  input  logic                 clk,
  input  logic [3:0]           en,
  input  logic [FRAC_BITS:0]   p,
  input  logic [FRAC_BITS:0]   sn,
  input  logic [FRAC_BITS:0]   s2,
  input  logic [ENERGY_BITS+FRAC_BITS:0]   m_r,
  input  logic [ENERGY_BITS+FRAC_BITS-8:0] m_q,
  output logic [FRAC_BITS:0]   weight
);

  localparam int F    = FRAC_BITS;
  localparam int E    = ENERGY_BITS;
  localparam int EO_W = E + F + 1;
  localparam int Q5_W = EO_W - 8;
  localparam int IP_W = ((F + 1 > Q5_W) ? F + 1 : Q5_W) + 1;
  localparam int T_W  = IP_W + 1;

  localparam logic [IP_W-1:0] ONE_IP  = IP_W'(1) << F;
  localparam logic [F:0]      OUT_MAX = '1;

  // stage 1: 1/P and P^2
  logic [2*F+1:0]  pp;
  logic [IP_W-1:0] ip_c;
  logic [IP_W-1:0] ip1;
  logic [F:0]      p1, p2_1, s2_1, sn1;

  assign pp   = p * p;
  assign ip_c = ONE_IP + IP_W'(m_q)
              + IP_W'(m_r >= EO_W'(knaw_pkg::REST_KEV));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ip1  <= ip_c;
      p1   <= p;
      p2_1 <= pp[2*F:F];
      s2_1 <= s2;
      sn1  <= sn;
    end
  end

  // stage 2: P + 1/P - sin^2, floored at zero
  logic signed [T_W:0] tsum;
  logic [T_W-1:0]      t2;
  logic [F:0]          p2_2, sn2;

  assign tsum = $signed((T_W+1)'(p1)) + $signed((T_W+1)'(ip1))
              - $signed((T_W+1)'(s2_1));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t2   <= tsum[T_W] ? '0 : tsum[T_W-1:0];
      p2_2 <= p2_1;
      sn2  <= sn1;
    end
  end

  // stage 3: P^2 * t
  logic [F+T_W:0] ut;
  logic [T_W-1:0] u3;
  logic [F:0]     sn3;

  assign ut = p2_2 * t2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      u3  <= ut[F+T_W-1:F];
      sn3 <= sn2;
    end
  end

  // stage 4: sin * u, saturate
  logic [F+T_W:0] wp;
  logic [T_W:0]   ws;

  assign wp = sn3 * u3;
  assign ws = wp[F+T_W:F];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      weight <= (|ws[T_W:F+1]) ? OUT_MAX : ws[F:0];
    end
  end

endmodule

/* rtl/klein_nishina_angular_weight.sv */
// Channel  | Signals                               | Word
// ---------+---------------------------------------+--------------------------------
// item     | item_valid, item_stall                | cos_angle (Q1.F), energy_kev
// result   | result_valid, result_stall            | weight (unsigned Q.F, saturated)
//
// One word per cycle sustained while result_stall is low; words pass through the
// front stages, the bit-per-stage divide and square-root pipeline, then the back stages.
// Reset (rst, synchronous) clears the stage valid bits; data regs are not reset.
// Each stage loads when it is empty or its successor loads, so bubbles close
// up under result_stall; item_stall rises only when every stage holds a word.
`include "klein_nishina_angular_weight_defines.svh"

module klein_nishina_angular_weight #(
  parameter int FRAC_BITS   = knaw_pkg::FRAC_BITS_DEF,
  parameter int ENERGY_BITS = knaw_pkg::ENERGY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic signed [FRAC_BITS+1:0] cos_angle,
  input  logic [ENERGY_BITS-1:0]      energy_kev,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [FRAC_BITS:0]          weight
);

  localparam int F    = FRAC_BITS;
  localparam int E    = ENERGY_BITS;
  localparam int SQ_W = 2*F + 1;
  localparam int EO_W = E + F + 1;
  localparam int AV_W = F + 9;
  localparam int D_W  = ((AV_W > EO_W) ? AV_W : EO_W) + 1;
  localparam int Q5_W = EO_W - 8;
  localparam int N_IT = F + 1;        // iteration stages
  localparam int NS   = 3 + N_IT + 4; // front + iterations + back

  // Stage valid bits and load enables. en[k] high: stage k takes the word
  // from stage k-1 this cycle.
  logic [NS-1:0] vld;
  logic [NS-1:0] en;
  logic [NS:0]   vchain;

  assign vchain       = {vld, item_valid};
  assign en[NS-1]     = !vld[NS-1] || !result_stall;
  assign item_stall   = !en[0];
  assign result_valid = vld[NS-1];

  genvar k;
  generate
    for (k = 0; k < NS-1; k++) begin : g_en
      assign en[k] = !vld[k] || en[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vchain[i];
        end
      end
    end
  end

  // Word buses between stages; index j feeds iteration stage j,
  // index N_IT is the last iteration's output.
  logic [N_IT:0][SQ_W-1:0] s_rem;
  logic [N_IT:0][F:0]      s_root;
  logic [N_IT:0][F:0]      s2;
  logic [N_IT:0][D_W-1:0]  dv;
  logic [N_IT:0][D_W-1:0]  d_r;
  logic [N_IT:0][F:0]      d_q;
  logic [N_IT:0][EO_W-1:0] m_r;
  logic [N_IT:0][Q5_W-1:0] m_q;

  // clip, squares and products, iteration seeds
  knaw_front #(
    .FRAC_BITS   (F),
    .ENERGY_BITS (E)
  ) u_front (
    .clk        (clk),
    .en         (en[2:0]),
    .cos_angle  (cos_angle),
    .energy_kev (energy_kev),
    .s_rem      (s_rem[0]),
    .s_root     (s_root[0]),
    .s2         (s2[0]),
    .dv         (dv[0]),
    .d_r        (d_r[0]),
    .d_q        (d_q[0]),
    .m_r        (m_r[0]),
    .m_q        (m_q[0])
  );

  // sqrt bit, divide bit and mod-511 fold per stage
  generate
    for (k = 0; k < N_IT; k++) begin : g_it
      knaw_iter #(
        .FRAC_BITS   (F),
        .ENERGY_BITS (E),
        .STEP        (k)
      ) u_iter (
        .clk      (clk),
        .en       (en[3+k]),
        .pre_rem  (s_rem[k]),
        .pre_root (s_root[k]),
        .pre_s2   (s2[k]),
        .pre_dv   (dv[k]),
        .pre_d_r  (d_r[k]),
        .pre_d_q  (d_q[k]),
        .pre_m_r  (m_r[k]),
        .pre_m_q  (m_q[k]),
        .rem      (s_rem[k+1]),
        .root     (s_root[k+1]),
        .s2       (s2[k+1]),
        .dv       (dv[k+1]),
        .d_r      (d_r[k+1]),
        .d_q      (d_q[k+1]),
        .m_r      (m_r[k+1]),
        .m_q      (m_q[k+1])
      );
    end
  endgenerate

  // 1/P, P^2, polynomial and final sine product
  knaw_back #(
    .FRAC_BITS   (F),
    .ENERGY_BITS (E)
  ) u_back (
    .clk    (clk),
    .en     (en[NS-1:NS-4]),
    .p      (d_q[N_IT]),
    .sn     (s_root[N_IT]),
    .s2     (s2[N_IT]),
    .m_r    (m_r[N_IT]),
    .m_q    (m_q[N_IT]),
    .weight (weight)
  );

  // pipeline is empty right after reset
  `KNAW_ASSERT(a_reset_empty, $past(rst) |-> !result_valid)
  // input is held back only when the whole pipe is full and the output stalls
  `KNAW_ASSERT(a_stall_full, item_stall |-> (&vld) && result_stall)
  // a full pipe under output stall must hold the input
  `KNAW_ASSERT(a_full_holds, (&vld) && result_stall |-> item_stall)
  // a stalled result stays valid into the next cycle
  `KNAW_ASSERT(a_result_kept, result_valid && result_stall |=> result_valid)

endmodule
